/* src/amb_pkg.sv */
// Shared definitions for the alpha mask boundary point extractor.
// Holds register indexes, reset values, size constants and the control
// structs that pass between the raster, window and top-level modules.
package amb_pkg;

  // Default line and frame limits.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Field widths fixed by the register map and the output format.
  localparam int SIZE_REG_W = 11;
  localparam int COORD_W    = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int WIN_W      = 9;

  // Smallest frame edge that the counters accept.
  localparam logic [COORD_W-1:0] MIN_SIZE = 16'd3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 4'd3;

  // Register reset values.
  localparam logic [SIZE_REG_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [SIZE_REG_W-1:0] RST_IMAGE_HEIGHT = 11'd1024;

  // Window value when all nine pixels are opaque.
  localparam logic [WIN_W-1:0] WIN_ALL_OPAQUE = 9'h1FF;

  // Per-transaction control from the raster counters to the window stage.
  typedef struct packed {
    logic take;      // a pixel transaction is accepted this cycle
    logic opaque;    // the pixel alpha is nonzero
    logic interior;  // the window center lies off the top and left borders
  } det_ctl_t;

  // Status from the window stage back to the top level.
  typedef struct packed {
    logic busy;      // stage one holds a pixel
    logic fire;      // stage one retires a boundary pixel this cycle
  } det_stat_t;

endpackage

/* src/amb_line_buf.sv */
// Two-row opacity line buffer: one memory of two-bit entries, above and
// middle row, with a registered read and write-to-read forwarding.
// Depends on amb_pkg for the default depth.
module amb_line_buf #(
  parameter int MAX_WIDTH = amb_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [1:0]                   wr_data,
  output logic [1:0]                   rd_data
);

  // Bit 1 holds the row two above the newest pixel, bit 0 the row above.
  logic [1:0] mem [MAX_WIDTH];
  logic [1:0] mem_q;
  logic       fwd;
  logic [1:0] fwd_data;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; a write to the same entry in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd      <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd ? fwd_data : mem_q;

endmodule

/* src/amb_raster.sv */
// Raster position counters for the incoming pixel stream.
// Gives the column and row of each accepted pixel and flags interior pixels.
// Depends on amb_pkg.
module amb_raster #(
  parameter int MAX_WIDTH  = amb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = amb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  logic                              frame_start,
  input  logic [amb_pkg::SIZE_REG_W-1:0]    image_width,
  input  logic [amb_pkg::SIZE_REG_W-1:0]    image_height,
  output logic [$clog2(MAX_WIDTH)-1:0]      col,
  output logic [$clog2(MAX_HEIGHT)-1:0]     row,
  output logic                              interior
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SW = amb_pkg::COORD_W;

  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [SW-1:0] w_raw, h_raw, w_eff, h_eff;
  logic [SW-1:0] c0, r0, c1, r1, r2, cn, rn;

  // Clamp the configured sizes into the supported range.
  always_comb begin
    w_raw = SW'(image_width);
    h_raw = SW'(image_height);
    if (w_raw < amb_pkg::MIN_SIZE) begin
      w_eff = amb_pkg::MIN_SIZE;
    end else if (w_raw > SW'(MAX_WIDTH)) begin
      w_eff = SW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < amb_pkg::MIN_SIZE) begin
      h_eff = amb_pkg::MIN_SIZE;
    end else if (h_raw > SW'(MAX_HEIGHT)) begin
      h_eff = SW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  // Position of this pixel, then the position of the one after it.
  always_comb begin
    c0 = frame_start ? '0 : SW'(column_count);
    r0 = frame_start ? '0 : SW'(row_count);
    if (c0 >= w_eff) begin
      c1 = '0;
      r1 = r0 + 16'd1;
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = (r1 >= h_eff) ? '0 : r1;
    col = c1[CW-1:0];
    row = r2[RW-1:0];
    interior = (c1 >= 16'd2) && (r2 >= 16'd2);

    cn = c1 + 16'd1;
    rn = r2;
    if (cn >= w_eff) begin
      cn = '0;
      rn = r2 + 16'd1;
      if (rn >= h_eff) begin
        rn = '0;
      end
    end
    column_count_next = cn[CW-1:0];
    row_count_next    = rn[RW-1:0];
  end

  // Counter registers advance once per accepted pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (take) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

/* src/amb_detect.sv */
// Window stage: merges line buffer data with the new pixel, shifts the
// 3x3 window, writes the line buffer back and registers boundary points.
// Depends on amb_pkg.
module amb_detect #(
  parameter int MAX_WIDTH  = amb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = amb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  amb_pkg::det_ctl_t                    ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0]         col,
  input  logic [$clog2(MAX_HEIGHT)-1:0]        row,
  input  logic signed [amb_pkg::COORD_W-1:0]   origin_x,
  input  logic signed [amb_pkg::COORD_W-1:0]   origin_y,
  input  logic [1:0]                           line_data,
  output logic                                 line_wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0]         line_wr_addr,
  output logic [1:0]                           line_wr_data,
  output logic                                 hold,
  output amb_pkg::det_stat_t                   stat,
  input  logic                                 point_stall,
  output logic                                 point_valid,
  output logic signed [amb_pkg::COORD_W-1:0]   point_x,
  output logic signed [amb_pkg::COORD_W-1:0]   point_y
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SW = amb_pkg::COORD_W;

  logic                           s1_valid;
  logic [CW-1:0]                  s1_col;
  logic [RW-1:0]                  s1_row;
  logic                           s1_opaque;
  logic                           s1_interior;
  logic [amb_pkg::WIN_W-1:0]      window_bits, window_next;
  logic                           s1_adv, s1_fire, hit;

  // Stage one moves on unless a finished point is still waiting.
  assign s1_adv  = !point_valid || !point_stall;
  assign hold    = s1_valid && !s1_adv;
  assign s1_fire = s1_valid && s1_adv;

  // New window column: bit 0 top, bit 1 middle, bit 2 the new pixel.
  always_comb begin
    window_next = {s1_opaque, line_data[0], line_data[1], window_bits[8:3]};
    hit = s1_interior && window_next[4] && (window_next != amb_pkg::WIN_ALL_OPAQUE);
  end

  // Line buffer write-back: the middle row moves up, the new pixel enters.
  assign line_wr_en   = s1_fire;
  assign line_wr_addr = s1_col;
  assign line_wr_data = {line_data[0], s1_opaque};

  assign stat.busy = s1_valid;
  assign stat.fire = s1_fire && hit;

  // Stage one control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ctl.take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      s1_col      <= col;
      s1_row      <= row;
      s1_opaque   <= ctl.opaque;
      s1_interior <= ctl.interior;
    end
  end

  // The window shifts once per retired pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
    end else if (s1_fire) begin
      window_bits <= window_next;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (s1_fire && hit) begin
      point_valid <= 1'b1;
    end else if (!point_stall) begin
      point_valid <= 1'b0;
    end
  end

  // Output coordinates refer to the window center, one column and row back.
  always_ff @(posedge clk) begin
    if (s1_fire && hit) begin
      point_x <= SW'(s1_col) - 16'sd1 + origin_x;
      point_y <= SW'(s1_row) - 16'sd1 + origin_y;
    end
  end

endmodule

/* src/alpha_mask_boundary_points.sv */
// Top level of the alpha mask boundary point extractor: configuration
// registers, raster counters, opacity line buffer and window stage.
// Depends on amb_pkg, amb_raster, amb_line_buf and amb_detect.
//
//   Channel  Handshake                Payload
//   pixel    pixel_valid/pixel_stall  alpha, frame_start
//   point    point_valid/point_stall  point_x, point_y
//   cfg      cfg_valid/cfg_ready      cfg_index, cfg_data
//
// One pixel is accepted per clock unless the pixel channel stalls; a
// boundary point passes through stage one into the output register.
// The rate is set by the line buffer memory: one read per pixel at accept
// and a write-back when it retires from stage one, forwarding in between.
// Reset clears the counters, the window and the handshake state; the line
// buffer needs no clearing since an entry affects a point only after it
// has been written.
// The pixel channel stalls only while stage one holds a pixel and the
// output register is full and stalled.
module alpha_mask_boundary_points #(
  parameter int MAX_WIDTH  = amb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = amb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic [7:0]                          alpha,
  input  logic                                frame_start,
  output logic                                point_valid,
  input  logic                                point_stall,
  output logic signed [amb_pkg::COORD_W-1:0]  point_x,
  output logic signed [amb_pkg::COORD_W-1:0]  point_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [amb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [amb_pkg::COORD_W-1:0]         cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [amb_pkg::SIZE_REG_W-1:0]      image_width, image_height;
  logic signed [amb_pkg::COORD_W-1:0]  origin_x, origin_y;
  logic                                take;
  logic [CW-1:0]                       col;
  logic [RW-1:0]                       row;
  logic                                interior;
  amb_pkg::det_ctl_t                   ctl;
  amb_pkg::det_stat_t                  stat;
  logic                                line_wr_en;
  logic [CW-1:0]                       line_wr_addr;
  logic [1:0]                          line_wr_data, line_data;

  assign cfg_ready = 1'b1;
  assign take      = pixel_valid && !pixel_stall;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= amb_pkg::RST_IMAGE_WIDTH;
      image_height <= amb_pkg::RST_IMAGE_HEIGHT;
      origin_x     <= '0;
      origin_y     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        amb_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[amb_pkg::SIZE_REG_W-1:0];
        amb_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[amb_pkg::SIZE_REG_W-1:0];
        amb_pkg::REG_ORIGIN_X:     origin_x     <= cfg_data;
        amb_pkg::REG_ORIGIN_Y:     origin_y     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  amb_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .frame_start  (frame_start),
    .image_width  (image_width),
    .image_height (image_height),
    .col          (col),
    .row          (row),
    .interior     (interior)
  );

  // Control bundle for the window stage: accept, opacity, interior flag.
  assign ctl = {take, (alpha != 8'd0), interior};

  amb_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (col),
    .wr_en   (line_wr_en),
    .wr_addr (line_wr_addr),
    .wr_data (line_wr_data),
    .rd_data (line_data)
  );

  amb_detect #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_detect (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .col          (col),
    .row          (row),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .line_data    (line_data),
    .line_wr_en   (line_wr_en),
    .line_wr_addr (line_wr_addr),
    .line_wr_data (line_wr_data),
    .hold         (pixel_stall),
    .stat         (stat),
    .point_stall  (point_stall),
    .point_valid  (point_valid),
    .point_x      (point_x),
    .point_y      (point_y)
  );

  // The input stalls only behind a waiting, stalled point.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (stat.busy && point_valid && point_stall))
    else $error("pixel channel stalled without a blocked point");

  // A new point comes only from a pixel retired in the cycle before.
  a_point_source: assert property (@(posedge clk) disable iff (rst)
    $rose(point_valid) |-> $past(stat.fire))
    else $error("point appeared without a retired boundary pixel");

  // An accepted pixel always reaches stage one.
  a_stage_fill: assert property (@(posedge clk) disable iff (rst)
    take |=> stat.busy)
    else $error("accepted pixel did not enter the window stage");

endmodule

/* bench/tb_top.sv */
// Self-checking bench for alpha_mask_boundary_points: streams alpha masks and compares
// every boundary point against an in-module predictor or a directed expected point.
// Depends on amb_pkg and the alpha_mask_boundary_points RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Index width of the predictor line buffers.
  localparam int LB_AW = $clog2(amb_pkg::DEF_MAX_WIDTH);

  // How the stimulus rows of the opening directed section are checked.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_POINT} dir_chk_t;

  // Idle pattern on the two channels.
  typedef enum logic [1:0] {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_t;

  typedef struct packed {
    logic [amb_pkg::COORD_W-1:0] x;
    logic [amb_pkg::COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic [7:0]                  a;
    logic                        fs;
    dir_chk_t                    chk;
    logic [amb_pkg::COORD_W-1:0] ex_x;
    logic [amb_pkg::COORD_W-1:0] ex_y;
  } dir_row_t;

  typedef struct packed {
    logic [amb_pkg::COORD_W-1:0] w;
    logic [amb_pkg::COORD_W-1:0] h;
    logic [amb_pkg::COORD_W-1:0] ox;
    logic [amb_pkg::COORD_W-1:0] oy;
    logic                        rnd_org;
    logic                        fs_first;
    logic [11:0]                 n;
    logic [3:0]                  fs_noise;
    pace_t                       pace;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                pixel_valid = 1'b0;
  logic                                pixel_stall;
  logic [7:0]                          alpha = 8'd0;
  logic                                frame_start = 1'b0;
  logic                                point_valid;
  logic                                point_stall = 1'b0;
  logic signed [amb_pkg::COORD_W-1:0]  point_x;
  logic signed [amb_pkg::COORD_W-1:0]  point_y;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [amb_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [amb_pkg::COORD_W-1:0]         cfg_data = '0;

  // Predictor copy of the registers and the raster state.
  logic [amb_pkg::SIZE_REG_W-1:0] cfg_w = amb_pkg::RST_IMAGE_WIDTH;
  logic [amb_pkg::SIZE_REG_W-1:0] cfg_h = amb_pkg::RST_IMAGE_HEIGHT;
  logic [amb_pkg::COORD_W-1:0]    org_x = '0;
  logic [amb_pkg::COORD_W-1:0]    org_y = '0;
  bit                             above_q  [amb_pkg::DEF_MAX_WIDTH];
  bit                             middle_q [amb_pkg::DEF_MAX_WIDTH];
  logic [8:0]                     win = '0;
  int unsigned                    col_n = 0;
  int unsigned                    row_n = 0;

  point_t point_q [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;
  int pix_count = 0;
  int pt_count  = 0;
  int settings  = 0;

  // Opening directed stimulus. The first two rows run with the reset
  // registers; the rest use a 3x3 mask with origins at the extremes.
  dir_row_t dir_tab [0:19] = '{
    '{8'd255, 1'b1, CHK_MODEL, 16'h0, 16'h0},
    '{8'd0,   1'b0, CHK_MODEL, 16'h0, 16'h0},
    // Transparent corner around an opaque center: one point, origins wrap.
    '{8'd0,   1'b1, CHK_MODEL, 16'h0, 16'h0},
    '{8'd255, 1'b0, CHK_MODEL, 16'h0, 16'h0},
    '{8'd255, 1'b0, CHK_MODEL, 16'h0, 16'h0},
    '{8'd255, 1'b0, CHK_MODEL, 16'h0, 16'h0},
    '{8'd255, 1'b0, CHK_MODEL, 16'h0, 16'h0},
    '{8'd255, 1'b0, CHK_MODEL, 16'h0, 16'h0},
    '{8'd255, 1'b0, CHK_MODEL, 16'h0, 16'h0},
    '{8'd255, 1'b0, CHK_MODEL, 16'h0, 16'h0},
    '{8'd1,   1'b0, CHK_POINT, 16'h8000, 16'h8001},
    // Next mask starts by wrapping, no frame start; fully opaque window.
    '{8'h80,  1'b0, CHK_MODEL, 16'h0, 16'h0},
    '{8'h01,  1'b0, CHK_MODEL, 16'h0, 16'h0},
    '{8'hFF,  1'b0, CHK_MODEL, 16'h0, 16'h0},
    '{8'h7F,  1'b0, CHK_MODEL, 16'h0, 16'h0},
    '{8'h40,  1'b0, CHK_MODEL, 16'h0, 16'h0},
    '{8'h02,  1'b0, CHK_MODEL, 16'h0, 16'h0},
    '{8'hFE,  1'b0, CHK_MODEL, 16'h0, 16'h0},
    '{8'h10,  1'b0, CHK_MODEL, 16'h0, 16'h0},
    '{8'h08,  1'b0, CHK_MODEL, 16'h0, 16'h0}
  };

  // Random phases. Widths or heights outside 3..1024 exercise clamping;
  // phases without a leading frame start shrink the width mid-mask.
  phase_t runs [0:8] = '{
    '{16'd5,    16'd4,    16'h0,    16'h0,    1'b1, 1'b1, 12'd180, 4'd5, PACE_RX_SLOW},
    '{16'd2,    16'd0,    16'h8000, 16'h7FFF, 1'b0, 1'b1, 12'd180, 4'd5, PACE_RX_SLOW},
    '{16'hFFFF, 16'd3,    16'h0,    16'h0,    1'b0, 1'b1, 12'd160, 4'd0, PACE_RX_SLOW},
    '{16'd7,    16'd5,    16'h0,    16'h0,    1'b1, 1'b0, 12'd180, 4'd5, PACE_TX_SLOW},
    '{16'd12,   16'd9,    16'h0,    16'h0,    1'b1, 1'b1, 12'd200, 4'd5, PACE_TX_SLOW},
    '{16'd9,    16'h07FF, 16'h0,    16'h0,    1'b1, 1'b0, 12'd180, 4'd5, PACE_TX_SLOW},
    '{16'd4,    16'd6,    16'hFFFF, 16'h0001, 1'b0, 1'b1, 12'd180, 4'd5, PACE_FULL},
    '{16'd32,   16'd3,    16'h0,    16'h0,    1'b1, 1'b1, 12'd180, 4'd5, PACE_FULL},
    '{16'd3,    16'd3,    16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 12'd140, 4'd5, PACE_FULL}
  };

  alpha_mask_boundary_points DUT (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .alpha       (alpha),
    .frame_start (frame_start),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // Effective frame edge after clamping to the supported range.
  function automatic int unsigned size_clamp(input logic [amb_pkg::SIZE_REG_W-1:0] v,
                                             input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // Advances the raster and window by one pixel and tells whether the
  // window center is a boundary point, with its shifted position.
  function automatic bit predict_boundary(input logic [7:0] a, input logic fs,
                                          output point_t pt);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    bit cur;
    bit top;
    bit mid;
    bit hit;
    w = size_clamp(cfg_w, amb_pkg::DEF_MAX_WIDTH);
    h = size_clamp(cfg_h, amb_pkg::DEF_MAX_HEIGHT);
    cur = (a != 8'd0);
    hit = 1'b0;
    pt = '0;
    if (fs) begin
      col_n = 0;
      row_n = 0;
    end
    // Counters left past a shrunken size wrap before use.
    if (col_n >= w) begin
      col_n = 0;
      row_n++;
    end
    if (row_n >= h) row_n = 0;
    c = col_n;
    r = row_n;
    top = above_q[c[LB_AW-1:0]];
    mid = middle_q[c[LB_AW-1:0]];
    above_q[c[LB_AW-1:0]] = mid;
    middle_q[c[LB_AW-1:0]] = cur;
    win = {cur, mid, top, win[8:3]};
    // Borders are skipped; column 0 also holds a pixel of the row above.
    if (c >= 2 && r >= 2 && win[4] && win != '1) begin
      hit = 1'b1;
      pt.x = amb_pkg::COORD_W'(c - 1) + org_x;
      pt.y = amb_pkg::COORD_W'(r - 1) + org_y;
    end
    col_n = c + 1;
    if (col_n >= w) begin
      col_n = 0;
      row_n = r + 1;
      if (row_n >= h) row_n = 0;
    end
    return hit;
  endfunction

  task automatic set_pace(input pace_t p);
    case (p)
      PACE_RX_SLOW: begin
        idle_pct = 21;
        stall_pct = 83;
      end
      PACE_TX_SLOW: begin
        idle_pct = 83;
        stall_pct = 21;
      end
      default: begin
        idle_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  // Sends one pixel transaction and records what it should produce.
  // Valid stays high on return; the caller lowers it after a batch.
  task automatic send_pixel(input logic [7:0] a, input logic fs, input dir_chk_t chk,
                            input logic [amb_pkg::COORD_W-1:0] ex_x,
                            input logic [amb_pkg::COORD_W-1:0] ex_y);
    point_t p;
    bit hit;
    if ($urandom_range(0, 99) < idle_pct) begin
      pixel_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    pixel_valid <= 1'b1;
    alpha <= a;
    frame_start <= fs;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    pix_count++;
    hit = predict_boundary(a, fs, p);
    case (chk)
      CHK_POINT: begin
        p.x = ex_x;
        p.y = ex_y;
        point_q = {point_q, p};
      end
      CHK_MODEL: if (hit) point_q = {point_q, p};
      default: ;
    endcase
  endtask

  // Waits for every expected point, then for the pipeline to settle.
  task automatic drain_points();
    while (point_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [amb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [amb_pkg::COORD_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      amb_pkg::REG_IMAGE_WIDTH:  cfg_w = d[amb_pkg::SIZE_REG_W-1:0];
      amb_pkg::REG_IMAGE_HEIGHT: cfg_h = d[amb_pkg::SIZE_REG_W-1:0];
      amb_pkg::REG_ORIGIN_X:     org_x = d;
      amb_pkg::REG_ORIGIN_Y:     org_y = d;
      default: ;
    endcase
  endtask

  // Writes all four registers plus one index past the map, which is ignored.
  task automatic program_regs(input logic [amb_pkg::COORD_W-1:0] w,
                              input logic [amb_pkg::COORD_W-1:0] h,
                              input logic [amb_pkg::COORD_W-1:0] ox,
                              input logic [amb_pkg::COORD_W-1:0] oy);
    drain_points();
    cfg_write(amb_pkg::REG_IMAGE_WIDTH, w);
    cfg_write(amb_pkg::REG_IMAGE_HEIGHT, h);
    cfg_write(amb_pkg::REG_ORIGIN_X, ox);
    cfg_write(amb_pkg::REG_ORIGIN_Y, oy);
    cfg_write(amb_pkg::CFG_IDX_W'($urandom_range(amb_pkg::REG_ORIGIN_Y + 1,
                                                  2**amb_pkg::CFG_IDX_W - 1)),
              amb_pkg::COORD_W'($urandom));
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Point channel: compare each transaction and pick the next stall.
  always @(posedge clk) begin
    point_t want;
    if (!rst && point_valid && !point_stall) begin
      pt_count++;
      if (point_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected point x=%0d y=%0d", point_x, point_y);
      end else begin
        want = point_q.pop_front();
        if (point_x !== want.x || point_y !== want.y) begin
          errors++;
          if (errors <= 10)
            $display("point mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                     $signed(want.x), $signed(want.y), point_x, point_y);
        end
      end
    end
    point_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Stimulus sequence.
  initial begin
    logic [7:0] a;
    logic fs;
    logic opq;
    logic [amb_pkg::COORD_W-1:0] ox;
    logic [amb_pkg::COORD_W-1:0] oy;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed rows, first under reset values, then on a 3x3 mask.
    set_pace(PACE_RX_SLOW);
    for (int i = 0; i < 2; i++)
      send_pixel(dir_tab[i].a, dir_tab[i].fs, dir_tab[i].chk, dir_tab[i].ex_x, dir_tab[i].ex_y);
    pixel_valid <= 1'b0;
    program_regs(16'd3, 16'd3, 16'h7FFF, 16'h8000);
    for (int i = 2; i < 20; i++)
      send_pixel(dir_tab[i].a, dir_tab[i].fs, dir_tab[i].chk, dir_tab[i].ex_x, dir_tab[i].ex_y);
    pixel_valid <= 1'b0;

    // Random masks: runs of opaque and transparent pixels with some noise
    // and an occasional early frame start.
    opq = 1'b0;
    foreach (runs[p]) begin
      ox = runs[p].rnd_org ? amb_pkg::COORD_W'($urandom) : runs[p].ox;
      oy = runs[p].rnd_org ? amb_pkg::COORD_W'($urandom) : runs[p].oy;
      program_regs(runs[p].w, runs[p].h, ox, oy);
      set_pace(runs[p].pace);
      for (int k = 0; k < runs[p].n; k++) begin
        if (k == 0)
          fs = runs[p].fs_first;
        else if (col_n == 0 && row_n == 0)
          fs = 1'($urandom_range(0, 1));
        else
          fs = ($urandom_range(0, 999) < runs[p].fs_noise);
        if ($urandom_range(0, 99) < 6)
          opq = 1'($urandom_range(0, 1));
        else if ($urandom_range(0, 99) < 18)
          opq = ~opq;
        a = opq ? 8'($urandom_range(1, 255)) : 8'd0;
        send_pixel(a, fs, CHK_MODEL, '0, '0);
      end
      pixel_valid <= 1'b0;
    end

    drain_points();
    $display("Sent %0d pixels under %0d register settings; %0d points checked, %0d errors.",
             pix_count, settings, pt_count, errors);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
